// File: rtl/core/device_class_allocator_macros.svh
// ----------------------------------------------------------------------------
// Device class allocator assertion macros
// Shared assertion forms for the allocator modules, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef DEVICE_CLASS_ALLOCATOR_MACROS_SVH
`define DEVICE_CLASS_ALLOCATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("device class allocator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DCA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("device class allocator assertion failed");

`endif

// File: rtl/core/dca_pkg.sv
// ----------------------------------------------------------------------------
// Device class allocator package
// Sizes, codes and the structures that pass between the allocator modules.
// ----------------------------------------------------------------------------
package dca_pkg;

  localparam int NUM_CLASSES = 4;
  localparam int NUM_DEVICES = 16;

  localparam int DEV_W   = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
  localparam int CLS_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int PTR_W   = 5;
  localparam int BASE_W  = 4;
  localparam int CNT_W   = 5;
  localparam int JOB_W   = 8;
  localparam int CLSID_W = 4;
  localparam int LNUM_W  = 8;
  localparam int DEVNO_W = 4;
  localparam int FREED_W = 5;

  localparam int BASE_TBL_W = 16;
  localparam int CNT_TBL_W  = 20;
  localparam int MASK_W     = 16;
  localparam int CFG_W      = 20;
  localparam int CFG_IDX_W  = 2;

  localparam logic [MASK_W-1:0] GOOD_MASK_RESET = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLASS_BASE  = 2'd0,
    REG_CLASS_COUNT = 2'd1,
    REG_GOOD_MASK   = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_CLASS   = 2'd1,
    ST_NONE_FREE  = 2'd2,
    ST_HOLDS_NONE = 2'd3
  } status_t;

  typedef struct packed {
    logic [BASE_TBL_W-1:0] base_table;
    logic [CNT_TBL_W-1:0]  count_table;
    logic [MASK_W-1:0]     good_mask;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [JOB_W-1:0]   job_id;
    logic [CLSID_W-1:0] class_id;
    logic [LNUM_W-1:0]  logical_number;
  } req_t;

  typedef struct packed {
    status_t            status_code;
    logic [DEVNO_W-1:0] device_number;
    logic [FREED_W-1:0] released_count;
  } res_t;

endpackage

// File: rtl/core/dca_cfg_regs.sv
// ----------------------------------------------------------------------------
// Device class allocator configuration registers
// Decodes the write port into the class base, class count and good-mask
// registers.
// ----------------------------------------------------------------------------
module dca_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [dca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dca_pkg::CFG_W-1:0]     cfg_data,
  output dca_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_table  <= '0;
      cfg.count_table <= '0;
      cfg.good_mask   <= dca_pkg::GOOD_MASK_RESET;
    end else if (cfg_we) begin
      unique case (dca_pkg::reg_index_t'(cfg_index))
        dca_pkg::REG_CLASS_BASE: begin
          cfg.base_table <= cfg_data[dca_pkg::BASE_TBL_W-1:0];
        end
        dca_pkg::REG_CLASS_COUNT: begin
          cfg.count_table <= cfg_data[dca_pkg::CNT_TBL_W-1:0];
        end
        dca_pkg::REG_GOOD_MASK: begin
          cfg.good_mask <= cfg_data[dca_pkg::MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: rtl/core/dca_scan_unit.sv
// ----------------------------------------------------------------------------
// Device class allocator scan unit
// Holds the device table and walks a class range one entry per cycle with a
// single compare and increment unit, claiming or freeing devices.
// ----------------------------------------------------------------------------
`include "device_class_allocator_macros.svh"

module dca_scan_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  dca_pkg::req_t req,
  input  dca_pkg::cfg_t cfg,
  output logic          res_valid,
  input  logic          res_ready,
  output dca_pkg::res_t res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  logic                             op_kind;
  logic [dca_pkg::JOB_W-1:0]        op_job;
  logic [dca_pkg::LNUM_W-1:0]       op_lnum;
  logic [dca_pkg::PTR_W-1:0]        ptr;
  logic [dca_pkg::CNT_W-1:0]        remain;
  logic [dca_pkg::FREED_W-1:0]      freed;

  logic [dca_pkg::NUM_DEVICES-1:0]  dev_free;
  logic [dca_pkg::JOB_W-1:0]        dev_owner   [dca_pkg::NUM_DEVICES];
  logic [dca_pkg::LNUM_W-1:0]       dev_logical [dca_pkg::NUM_DEVICES];

  logic [dca_pkg::CLS_W-1:0]        cls_idx;
  logic                             cls_unknown;
  logic [dca_pkg::BASE_W-1:0]       cls_base;
  logic [dca_pkg::CNT_W-1:0]        cls_count;
  logic [dca_pkg::DEV_W-1:0]        idx;
  logic                             scan_end;
  logic                             alloc_hit;
  logic                             recycle_hit;

  assign cls_idx     = req.class_id[dca_pkg::CLS_W-1:0];
  assign cls_unknown = ({1'b0, req.class_id} >= (dca_pkg::CLSID_W+1)'(dca_pkg::NUM_CLASSES));
  assign cls_base    = cfg.base_table[cls_idx*dca_pkg::BASE_W +: dca_pkg::BASE_W];
  assign cls_count   = cfg.count_table[cls_idx*dca_pkg::CNT_W +: dca_pkg::CNT_W];

  assign idx         = ptr[dca_pkg::DEV_W-1:0];
  assign scan_end    = (remain == '0) ||
                       ({1'b0, ptr} >= (dca_pkg::PTR_W+1)'(dca_pkg::NUM_DEVICES));
  assign alloc_hit   = !op_kind && dev_free[idx] && cfg.good_mask[idx];
  assign recycle_hit = op_kind && !dev_free[idx] && (dev_owner[idx] == op_job);

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      dev_free <= '1;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_kind            <= req.kind;
            op_job             <= req.job_id;
            op_lnum            <= req.logical_number;
            ptr                <= dca_pkg::PTR_W'(cls_base);
            remain             <= cls_count;
            freed              <= '0;
            res.device_number  <= '0;
            res.released_count <= '0;
            if (cls_unknown) begin
              res.status_code <= dca_pkg::ST_NO_CLASS;
              state           <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            res.device_number  <= '0;
            res.released_count <= freed;
            if (!op_kind) begin
              res.status_code <= dca_pkg::ST_NONE_FREE;
            end else if (freed != '0) begin
              res.status_code <= dca_pkg::ST_OK;
            end else begin
              res.status_code <= dca_pkg::ST_HOLDS_NONE;
            end
            state <= S_DONE;
          end else if (alloc_hit) begin
            dev_free[idx]      <= 1'b0;
            dev_owner[idx]     <= op_job;
            dev_logical[idx]   <= op_lnum;
            res.status_code    <= dca_pkg::ST_OK;
            res.device_number  <= dca_pkg::DEVNO_W'(idx);
            res.released_count <= '0;
            state              <= S_DONE;
          end else begin
            if (recycle_hit) begin
              dev_free[idx] <= 1'b1;
              freed         <= freed + 1'b1;
            end
            ptr    <= ptr + 1'b1;
            remain <= remain - 1'b1;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `DCA_ASSERT_NEXT(a_scan_step, (state == S_SCAN) && !scan_end && !alloc_hit, (state == S_SCAN) && (remain == $past(remain) - 1'b1))
  `DCA_ASSERT_NEXT(a_claim_taken, (state == S_SCAN) && !scan_end && alloc_hit, !dev_free[$past(idx)] && (res.device_number == dca_pkg::DEVNO_W'($past(idx))))
  `DCA_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res))
  `DCA_ASSERT_SAME(a_devnum_zero, res_valid && (res.status_code != dca_pkg::ST_OK || op_kind), res.device_number == '0)

endmodule

// File: rtl/core/device_class_allocator.sv
// ----------------------------------------------------------------------------
// Device class allocator
// Allocates and recycles devices grouped into classes over a stream
// interface, with a plain configuration write port.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// s_*       in         s_tvalid/s_tready   request word, kind in s_tuser
// m_*       out        m_tvalid/m_tready   result word
// cfg_*     in         cfg_we              register index and data
//
// A request is taken in the idle state; the scan then walks the class range one
// device entry per cycle until an allocate claims a free good device or the
// range or the table ends, and the result waits in the done state.
// An unknown class skips the scan. Reset marks every device free.
// The output register lets a new request be taken while a result waits.
// ----------------------------------------------------------------------------
module device_class_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // job_id [7:0], class_id [11:8], logical_number [19:12], zero [23:20]
  input  logic [23:0]                   s_tdata,
  // kind [0]
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status_code [1:0], device_number [5:2], released_count [10:6], zero [15:11]
  output logic [15:0]                   m_tdata,
  input  logic                          cfg_we,
  input  logic [dca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dca_pkg::CFG_W-1:0]     cfg_data
);

  dca_pkg::cfg_t cfg;
  dca_pkg::req_t req;
  dca_pkg::res_t res;
  logic          res_valid;
  logic          res_ready;

  assign req.kind           = s_tuser;
  assign req.job_id         = s_tdata[7:0];
  assign req.class_id       = s_tdata[11:8];
  assign req.logical_number = s_tdata[19:12];

  dca_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dca_scan_unit u_scan (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req       (req),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
      if (res_valid) begin
        m_tdata <= {5'd0, res.released_count, res.device_number, res.status_code};
      end
    end
  end

endmodule
